// ===== rtl/core/sprite_draw_order_sort_macros.svh =====
// assertion macros shared by the sprite draw order sort rtl
`ifndef SPRITE_DRAW_ORDER_SORT_MACROS_SVH
`define SPRITE_DRAW_ORDER_SORT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SDOS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define SDOS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/sdos_pkg.sv =====
// types, constants and key function for the sprite draw order sort
package sdos_pkg;

  localparam int MAX_SPRITES = 64;
  localparam int CNT_W       = $clog2(MAX_SPRITES + 1);
  localparam int KEY_W       = 35;
  localparam int HANDLE_W    = 6;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic ins;    // place the broadcast entry
    logic shift;  // move every entry one place toward the head
  } cell_ctrl_t;

  // layer | biased depth | biased x+y, compares as unsigned
  function automatic logic [KEY_W-1:0] make_key(
    input logic [1:0]         layer,
    input logic signed [15:0] depth,
    input logic signed [15:0] px,
    input logic signed [15:0] py
  );
    logic [16:0] sum;
    sum = {px[15], px} + {py[15], py};
    return {layer, ~depth[15], depth[14:0], ~sum[16], sum[15:0]};
  endfunction

endpackage

// ===== rtl/core/sdos_cell.sv =====
// one slot of the sorted insertion chain
module sdos_cell (
  input  logic                clk,
  input  sdos_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  sdos_pkg::entry_t    new_ent,
  input  sdos_pkg::entry_t    prev_ent,
  input  logic                prev_gt,
  input  sdos_pkg::entry_t    next_ent,
  output sdos_pkg::entry_t    ent,
  output logic                gt
);
  import sdos_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // an empty slot counts as greater than any key
  assign gt  = !occupied || (ent_r.key > new_ent.key);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.shift) begin
      ent_nxt = next_ent;
    end else if (ctrl.ins && gt) begin
      ent_nxt = prev_gt ? prev_ent : new_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ===== rtl/core/sprite_draw_order_sort.sv =====
// sprite draw order sort: one sprite enters the insertion chain per cycle while loading.
// a set ends with tlast; the first handle appears the cycle after that transfer,
// then one handle per cycle while out_tready is high, n handles for n stored sprites.
// the output run drains the chain from its head; no input is taken until the last handle.
// synchronous active-low reset clears the count, the drop flag and the mode;
// slot contents are left as they are and only occupied slots are ever read.
module sprite_draw_order_sort (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // handle[5:0], layer_code[7:6], depth[23:8],
                                  // pos_x[39:24], pos_y[55:40]
  input  logic        in_tlast,   // final_entry
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_handle[5:0], zero fill[7:6]
  output logic        out_tlast,  // run_end
  output logic        out_tuser   // overflow
);
  import sdos_pkg::*;

  `include "sprite_draw_order_sort_macros.svh"

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SPRITES);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  logic             mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             drop_r, drop_nxt;

  logic       in_xfer, out_xfer, ins;
  cell_ctrl_t ctrl;
  entry_t     new_ent;
  entry_t     ents [MAX_SPRITES];
  logic       gts  [MAX_SPRITES];

  assign new_ent.handle = in_tdata[5:0];
  assign new_ent.key    = make_key(in_tdata[7:6], in_tdata[23:8], in_tdata[39:24],
                                   in_tdata[55:40]);

  assign in_tready = (mode_r == ST_LOAD);
  assign in_xfer   = in_tvalid && in_tready;
  assign ins       = in_xfer && (cnt_r != MAX_CNT);

  assign out_tvalid = (mode_r == ST_DRAIN);
  assign out_xfer   = out_tvalid && out_tready;
  assign out_tdata  = {2'b00, ents[0].handle};
  assign out_tlast  = (cnt_r == ONE_CNT);
  assign out_tuser  = drop_r;

  assign ctrl.ins   = ins;
  assign ctrl.shift = out_xfer;

  for (genvar i = 0; i < MAX_SPRITES; i++) begin : g_slot
    entry_t prev_e, next_e;
    logic   prev_g;
    if (i == 0) begin : g_head
      assign prev_e = new_ent;
      assign prev_g = 1'b0;
    end else begin : g_mid
      assign prev_e = ents[i-1];
      assign prev_g = gts[i-1];
    end
    if (i == MAX_SPRITES - 1) begin : g_tail
      assign next_e = new_ent;
    end else begin : g_body
      assign next_e = ents[i+1];
    end
    sdos_cell u_slot (
      .clk      (clk),
      .ctrl     (ctrl),
      .occupied (cnt_r > CNT_W'(i)),
      .new_ent  (new_ent),
      .prev_ent (prev_e),
      .prev_gt  (prev_g),
      .next_ent (next_e),
      .ent      (ents[i]),
      .gt       (gts[i])
    );
  end

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;
    case (mode_r)
      ST_LOAD: begin
        if (ins) begin
          cnt_nxt = cnt_r + ONE_CNT;
        end
        if (in_xfer && !ins) begin
          drop_nxt = 1'b1;
        end
        if (in_xfer && in_tlast) begin
          mode_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_xfer) begin
          cnt_nxt = cnt_r - ONE_CNT;
          if (out_tlast) begin
            drop_nxt = 1'b0;
            mode_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        mode_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ST_LOAD;
      cnt_r  <= '0;
      drop_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      drop_r <= drop_nxt;
    end
  end

  `SDOS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= MAX_CNT, "entry count above capacity")
  `SDOS_ASSERT_NOW(a_drain_nonempty, out_tvalid, cnt_r != '0, "drain with empty chain")
  `SDOS_ASSERT_NEXT(a_run_clears, out_xfer && out_tlast,
                    cnt_r == '0 && !drop_r && in_tready, "run end left state behind")
  `SDOS_ASSERT_NEXT(a_last_starts, in_xfer && in_tlast, out_tvalid, "final sprite gave no run")
  `SDOS_ASSERT_NEXT(a_load_counts, in_xfer && !in_tlast && cnt_r != MAX_CNT,
                    cnt_r == $past(cnt_r) + ONE_CNT, "load did not grow the count")

endmodule

// ===== sim/tb.sv =====
// testbench for sprite_draw_order_sort: stream stimulus, draw order prediction, result checks
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdos_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_ITEMS = 64;

  typedef struct {
    logic [HANDLE_W-1:0] handle;
    logic [1:0]          layer;
    logic signed [15:0]  depth;
    logic signed [15:0]  px;
    logic signed [15:0]  py;
    logic                last;
  } sprite_t;

  typedef struct {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } slot_t;

  typedef struct {
    logic [HANDLE_W-1:0] handle;
    logic                run_end;
    logic                overflow;
  } draw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  // predictor state: sorted sprites of the open set and its drop flag
  slot_t stored_sprites[$];
  logic  set_dropped = 1'b0;
  draw_t pending_draws[$];

  int   mismatches = 0;
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic hold_active = 1'b0;

  always #10 clk = ~clk;

  sprite_draw_order_sort u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // layer, then biased depth, then biased x+y: compares as unsigned
  function automatic logic [KEY_W-1:0] order_key(input sprite_t s);
    logic signed [16:0] sum;
    sum = 17'(s.px) + 17'(s.py);
    return {s.layer, s.depth ^ 16'h8000, sum ^ 17'h10000};
  endfunction

  function automatic void admit_sprite(input sprite_t s);
    slot_t e;
    draw_t d;
    int pos;
    if (stored_sprites.size() < MAX_SPRITES) begin
      e.key = order_key(s);
      e.handle = s.handle;
      pos = stored_sprites.size();
      // equal keys stay behind earlier arrivals
      while (pos > 0 && stored_sprites[pos-1].key > e.key) pos--;
      stored_sprites.insert(pos, e);
    end else begin
      set_dropped = 1'b1;
    end
    if (s.last) begin
      foreach (stored_sprites[k]) begin
        d.handle = stored_sprites[k].handle;
        d.run_end = (k == stored_sprites.size() - 1);
        d.overflow = set_dropped;
        pending_draws.push_back(d);
      end
      stored_sprites.delete();
      set_dropped = 1'b0;
    end
  endfunction

  function automatic sprite_t mk(input int h, input int l, input logic [15:0] d,
                                 input logic [15:0] x, input logic [15:0] y, input bit last);
    sprite_t s;
    s.handle = HANDLE_W'(h);
    s.layer = 2'(l);
    s.depth = d;
    s.px = x;
    s.py = y;
    s.last = last;
    return s;
  endfunction

  // extremes and a few small values so that ties turn up often
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(2)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sprite_t random_sprite(input bit last);
    return mk($urandom_range(63), $urandom_range(3), rand_coord(), rand_coord(),
              rand_coord(), last);
  endfunction

  task automatic send_sprite(input sprite_t s);
    if (!calm && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {s.py, s.px, s.depth, s.layer, s.handle};
    in_tlast <= s.last;
    do @(posedge clk); while (!in_tready);
    admit_sprite(s);
  endtask

  task automatic drain_draws();
    in_tvalid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_sprite();
    send_sprite(mk(63, 3, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1));
    send_sprite(mk(0, 0, 16'h8000, 16'h8000, 16'h8000, 1'b1));
  endtask

  task automatic test_key_order();
    send_sprite(mk(1, 1, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_sprite(mk(2, 0, 16'h7fff, 16'h0000, 16'h0000, 1'b0));
    send_sprite(mk(3, 0, 16'h8000, 16'h0000, 16'h0000, 1'b0));
    send_sprite(mk(4, 2, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_sprite(mk(5, 3, 16'h8000, 16'h8000, 16'h8000, 1'b0));
    send_sprite(mk(6, 0, 16'h0000, 16'h7fff, 16'h7fff, 1'b0));
    send_sprite(mk(7, 0, 16'h0000, 16'h8000, 16'h8000, 1'b0));
    send_sprite(mk(8, 0, 16'h0000, 16'h8000, 16'h7fff, 1'b0));
    // three equal keys: arrival order must hold
    send_sprite(mk(9, 0, 16'h0000, 16'h0001, 16'hffff, 1'b0));
    send_sprite(mk(10, 0, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_sprite(mk(11, 0, 16'h0000, 16'h0005, 16'hfffb, 1'b1));
  endtask

  task automatic test_capacity();
    // exactly full, no drop
    for (int i = 0; i < MAX_SPRITES; i++) send_sprite(random_sprite(i == MAX_SPRITES - 1));
    drain_draws();
    // two dropped, the second of them ends the set
    for (int i = 0; i < MAX_SPRITES + 2; i++) send_sprite(random_sprite(i == MAX_SPRITES + 1));
    drain_draws();
  endtask

  task automatic test_output_backpressure();
    for (int i = 0; i < 10; i++) begin
      if (i == 9) hold_req = 1'b1;
      send_sprite(random_sprite(i == 9));
    end
    // next set is offered while the run is held back
    for (int i = 0; i < 5; i++) send_sprite(random_sprite(i == 4));
    drain_draws();
  endtask

  task automatic test_random_sets();
    int sent;
    int set_len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(19) == 0) set_len = $urandom_range(62, 68);
      else set_len = $urandom_range(1, 9);
      for (int i = 0; i < set_len; i++) begin
        calm = (sent >= 16 && sent < 48);
        send_sprite(random_sprite(i == set_len - 1));
        sent++;
      end
      if ($urandom_range(7) == 0) drain_draws();
    end
    calm = 1'b0;
  endtask

  // long receiver hold-off, counted here
  initial begin
    forever begin
      wait (hold_req);
      @(posedge clk);
      hold_active <= 1'b1;
      for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      hold_active <= 1'b0;
      hold_req = 1'b0;
    end
  end

  always @(posedge clk) begin : check_draws
    draw_t want;
    if (out_tvalid && out_tready) begin
      if (pending_draws.size() == 0) begin
        report_mismatch($sformatf("handle %0d with nothing pending", out_tdata[5:0]));
      end else begin
        want = pending_draws.pop_front();
        if (out_tdata !== {2'b00, want.handle})
          report_mismatch($sformatf("tdata %h, want handle %0d", out_tdata, want.handle));
        if (out_tlast !== want.run_end)
          report_mismatch($sformatf("run_end %b, want %b", out_tlast, want.run_end));
        if (out_tuser !== want.overflow)
          report_mismatch($sformatf("overflow %b, want %b", out_tuser, want.overflow));
      end
    end
    if (hold_active) out_tready <= 1'b0;
    else out_tready <= calm || ($urandom_range(99) >= 30);
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_sprite();
    test_key_order();
    drain_draws();
    test_capacity();
    test_output_backpressure();
    test_random_sets();
    drain_draws();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_draws.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("FAIL");
    $finish;
  end

endmodule
